[sv/stunbr_pkg.sv]
// ----------------------------------------------------------------------------
// STUN binding-response parser package
// Shared constants, status codes and the result record of the parser.
// ----------------------------------------------------------------------------
package stunbr_pkg;

   localparam logic [31:0] STUN_COOKIE        = 32'h2112A442;
   localparam logic [15:0] BINDING_RESPONSE   = 16'h0101;
   localparam logic [15:0] XOR_MAPPED_ADDRESS = 16'h0020;
   localparam logic [15:0] XMA_VALUE_LENGTH   = 16'd8;
   localparam logic [7:0]  FAMILY_IPV4        = 8'h01;
   localparam int          HEADER_BYTES       = 20;

   localparam int          CSR_ADDR_WIDTH     = 4;
   localparam int          CSR_DATA_WIDTH     = 64;
   localparam logic        CSR_TXID_HIGH      = 1'b0;
   localparam logic        CSR_TXID_LOW       = 1'b1;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_BAD_HEADER  = 3'd1,
      STATUS_ID_MISMATCH = 3'd2,
      STATUS_TRUNC_MSG   = 3'd3,
      STATUS_TRUNC_ATTR  = 3'd4,
      STATUS_TRUNC_PAD   = 3'd5,
      STATUS_NO_ADDRESS  = 3'd6
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] mapped_port;
      logic [31:0] mapped_address;
   } result_type;

endpackage

[sv/stun_binding_response_parser.sv]
// ----------------------------------------------------------------------------
// STUN binding-response parser
// Parses a STUN binding response byte by byte and reports the IPv4
// XOR-MAPPED-ADDRESS with a status on the packet's final byte.
// ----------------------------------------------------------------------------
// The parser takes one packet byte per clock cycle without pauses of its own.
// Each accepted item passes an input register and then the parser core, which
// updates the packet state; the item that carries the last-byte mark, once
// it leaves the input register, loads the core's result into the result
// register. Items that are not marked last produce no result and never
// wait for the result register, so the next packet's bytes flow in while a
// result waits; only a last-marked item waits while an earlier result is still
// held. The expected transaction id is set through the register port at byte
// addresses 0 (upper 32 bits) and 8 (lower 64 bits).
module stun_binding_response_parser #(
   parameter int POSITION_WIDTH = 17
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [2:0]                           rsp_status,
   output logic [15:0]                          rsp_mapped_port,
   output logic [31:0]                          rsp_mapped_address,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [stunbr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [stunbr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [stunbr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);
   import stunbr_pkg::*;

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   result_type  result;
   logic        advance;
   logic        accept;
   logic [31:0] txid_high;
   logic [63:0] txid_low;

   stunbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .txid_high   (txid_high),
      .txid_low    (txid_low)
   );

   stunbr_parse #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .txid_high (txid_high),
      .txid_low  (txid_low),
      .result    (result)
   );

   assign advance      = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = (out_valid_ff && !rsp_ready) || (advance && in_last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_ff <= result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_status         = out_ff.status;
   assign rsp_mapped_port    = out_ff.mapped_port;
   assign rsp_mapped_address = out_ff.mapped_address;

endmodule

[sv/stunbr_csr.sv]
// ----------------------------------------------------------------------------
// STUN parser configuration registers
// APB-style register file holding the expected 96-bit transaction id.
// ----------------------------------------------------------------------------
module stunbr_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [stunbr_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [stunbr_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [stunbr_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready,
   output logic [31:0]                          txid_high,
   output logic [63:0]                          txid_low
);
   import stunbr_pkg::*;

   logic [31:0] txid_high_ff;
   logic [63:0] txid_low_ff;
   logic        write_en;
   logic        reg_sel;

   assign write_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = csr_paddr[3];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         txid_high_ff <= '0;
         txid_low_ff  <= '0;
      end else if (write_en) begin
         if (reg_sel == CSR_TXID_HIGH) begin
            txid_high_ff <= csr_pwdata[31:0];
         end else begin
            txid_low_ff <= csr_pwdata;
         end
      end
   end

   always_comb begin
      if (reg_sel == CSR_TXID_LOW) begin
         csr_prdata = txid_low_ff;
      end else begin
         csr_prdata = {32'd0, txid_high_ff};
      end
   end

   assign txid_high = txid_high_ff;
   assign txid_low  = txid_low_ff;

endmodule

[sv/stunbr_parse.sv]
// ----------------------------------------------------------------------------
// STUN packet parser core
// Holds the per-packet state, checks the header, walks the attributes and
// forms the result of the final byte.
// ----------------------------------------------------------------------------
module stunbr_parse #(
   parameter int POSITION_WIDTH = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   input  logic [31:0]            txid_high,
   input  logic [63:0]            txid_low,
   output stunbr_pkg::result_type result
);
   import stunbr_pkg::*;

   localparam int PW = POSITION_WIDTH;
   localparam int W  = POSITION_WIDTH + 1;

   logic [PW-1:0] pos_ff;
   logic          header_fault_ff, header_fault_in;
   logic          id_mismatch_ff, id_mismatch_in;
   logic [15:0]   msg_len_ff, msg_len_in;
   logic [PW-1:0] next_start_ff, next_start_in;
   logic [15:0]   attr_kind_ff, attr_kind_in;
   logic [15:0]   attr_len_ff, attr_len_in;
   logic [7:0]    family_ff, family_in;
   status_type    walk_ff, walk_in;
   logic [15:0]   port_ff, port_in;
   logic [31:0]   addr_ff, addr_in;

   logic [159:0]  hdr_expect;
   logic [4:0]    hdr_idx;
   logic [4:0]    hdr_sel;
   logic [7:0]    want;
   logic          in_header;
   logic [W-1:0]  p_ext;
   logic [W-1:0]  end_pos;
   logic [W-1:0]  off;
   logic          walk_active;
   logic          at_or_after;
   logic [PW-1:0] k;
   logic [PW-1:0] value_start;
   logic          in_value;
   logic [PW-1:0] rel;
   logic [15:0]   len_new;
   logic [16:0]   padded;
   logic [W-1:0]  size;
   status_type    status;

   assign hdr_idx    = pos_ff[4:0];
   assign hdr_sel    = 5'd19 - hdr_idx;
   assign hdr_expect = {BINDING_RESPONSE, 16'd0, STUN_COOKIE, txid_high, txid_low};
   assign want       = hdr_expect[{hdr_sel, 3'b000} +: 8];
   assign in_header  = pos_ff < PW'(HEADER_BYTES);

   assign p_ext       = W'(pos_ff);
   assign end_pos     = W'(HEADER_BYTES) + W'(msg_len_ff);
   assign off         = p_ext + W'(1);
   assign walk_active = !in_header && (p_ext < end_pos) && (walk_ff == STATUS_NO_ADDRESS);
   assign at_or_after = pos_ff >= next_start_ff;
   assign k           = pos_ff - next_start_ff;
   assign value_start = next_start_ff - PW'(8);
   assign in_value    = (attr_kind_ff == XOR_MAPPED_ADDRESS) && (attr_len_ff == XMA_VALUE_LENGTH)
                        && (next_start_ff >= PW'(8)) && (pos_ff >= value_start);
   assign rel         = pos_ff - value_start;
   assign len_new     = {attr_len_ff[15:8], data_byte};
   assign padded      = (17'(len_new) + 17'd3) & ~17'd3;

   always_comb begin
      header_fault_in = header_fault_ff;
      id_mismatch_in  = id_mismatch_ff;
      msg_len_in      = msg_len_ff;
      next_start_in   = next_start_ff;
      attr_kind_in    = attr_kind_ff;
      attr_len_in     = attr_len_ff;
      family_in       = family_ff;
      walk_in         = walk_ff;
      port_in         = port_ff;
      addr_in         = addr_ff;
      if (in_header) begin
         if (hdr_idx inside {[5'd2:5'd3]}) begin
            msg_len_in = {msg_len_ff[7:0], data_byte};
         end else if (hdr_idx inside {[5'd8:5'd19]}) begin
            if (data_byte != want) begin
               id_mismatch_in = 1'b1;
            end
         end else if (data_byte != want) begin
            header_fault_in = 1'b1;
         end
      end else if (walk_active) begin
         if (at_or_after) begin
            if (k[PW-1:2] == '0) begin
               case (k[1:0])
                  2'd0: begin
                     attr_kind_in = {data_byte, 8'd0};
                  end
                  2'd1: begin
                     attr_kind_in = {attr_kind_ff[15:8], data_byte};
                  end
                  2'd2: begin
                     attr_len_in = {data_byte, 8'd0};
                  end
                  default: begin
                     attr_len_in = len_new;
                     if (off + W'(len_new) > end_pos) begin
                        walk_in = STATUS_TRUNC_ATTR;
                     end else if (attr_kind_ff == XOR_MAPPED_ADDRESS
                                  && len_new == XMA_VALUE_LENGTH) begin
                        next_start_in = PW'(off + W'(8));
                     end else if (W'(padded) > end_pos - off) begin
                        walk_in = STATUS_TRUNC_PAD;
                     end else begin
                        next_start_in = PW'(off + W'(padded));
                     end
                  end
               endcase
            end
         end else if (in_value) begin
            if (rel[2:0] == 3'd1) begin
               family_in = data_byte;
            end else if (rel[2:0] inside {[3'd2:3'd3]}) begin
               port_in = {port_ff[7:0], data_byte};
            end else if (rel[2:0] inside {[3'd4:3'd7]}) begin
               addr_in = {addr_ff[23:0], data_byte};
               if (rel[2:0] == 3'd7 && family_ff == FAMILY_IPV4) begin
                  walk_in = STATUS_OK;
               end
            end
         end
      end
   end

   assign size = p_ext + W'(1);

   always_comb begin
      if (size < W'(HEADER_BYTES) || header_fault_in) begin
         status = STATUS_BAD_HEADER;
      end else if (id_mismatch_in) begin
         status = STATUS_ID_MISMATCH;
      end else if (msg_len_in[1:0] != 2'd0
                   || W'(HEADER_BYTES) + W'(msg_len_in) > size) begin
         status = STATUS_TRUNC_MSG;
      end else begin
         status = walk_in;
      end
      result.status = status;
      if (status == STATUS_OK) begin
         result.mapped_port    = port_in ^ STUN_COOKIE[31:16];
         result.mapped_address = addr_in ^ STUN_COOKIE;
      end else begin
         result.mapped_port    = '0;
         result.mapped_address = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         pos_ff          <= '0;
         header_fault_ff <= 1'b0;
         id_mismatch_ff  <= 1'b0;
         msg_len_ff      <= '0;
         next_start_ff   <= PW'(HEADER_BYTES);
         attr_kind_ff    <= '0;
         attr_len_ff     <= '0;
         family_ff       <= '0;
         walk_ff         <= STATUS_NO_ADDRESS;
         port_ff         <= '0;
         addr_ff         <= '0;
      end else if (step) begin
         if (pos_ff != '1) begin
            pos_ff <= pos_ff + PW'(1);
         end
         header_fault_ff <= header_fault_in;
         id_mismatch_ff  <= id_mismatch_in;
         msg_len_ff      <= msg_len_in;
         next_start_ff   <= next_start_in;
         attr_kind_ff    <= attr_kind_in;
         attr_len_ff     <= attr_len_in;
         family_ff       <= family_in;
         walk_ff         <= walk_in;
         port_ff         <= port_in;
         addr_ff         <= addr_in;
      end
   end

endmodule
